// ----- rtl/rail_fence_transposer_unit_macros.svh -----
// assertion macros shared by the rtl files
`ifndef RAIL_FENCE_TRANSPOSER_UNIT_MACROS_SVH
`define RAIL_FENCE_TRANSPOSER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

`define RFT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rft check failed");

`define RFT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rft check failed");

`else

`define RFT_ASSERT_IMPLY(label, clk, rst, ante, cons)

`define RFT_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/rft_pkg.sv -----
`default_nettype none

package rft_pkg;

   localparam int MAX_LEN_DEFAULT   = 64;
   localparam int MAX_RAILS_DEFAULT = 16;

   localparam int BYTE_W      = 8;
   localparam int RAIL_CFG_W  = 5;
   localparam int CSR_DATA_W  = 5;
   localparam int CSR_INDEX_W = 1;
   // wide enough for any legal buffer depth or rail count
   localparam int CNT_W       = 7;

   localparam logic [RAIL_CFG_W-1:0] RAIL_COUNT_RESET = 5'd2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_RAIL_COUNT  = 1'b0,
      CSR_DECODE_MODE = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [CNT_W-1:0] len;
      logic [CNT_W-1:0] rails;
      logic             truncated;
      logic             decode;
      logic             passthru;
   } job_type;

   typedef struct packed {
      logic              en;
      logic [CNT_W-1:0]  addr;
      logic [BYTE_W-1:0] data;
   } buf_write_type;

endpackage

`default_nettype wire

// ----- rtl/rft_front.sv -----
`default_nettype none

`include "rail_fence_transposer_unit_macros.svh"

module rft_front #(
   parameter int MAX_LEN   = rft_pkg::MAX_LEN_DEFAULT,
   parameter int MAX_RAILS = rft_pkg::MAX_RAILS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [rft_pkg::BYTE_W-1:0]          req_tdata,
   input  logic                                req_tlast,
   input  logic                                csr_we,
   input  logic [rft_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [rft_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                queue_empty,
   input  logic                                back_busy,
   output logic                                job_push,
   output rft_pkg::job_type                    job,
   output rft_pkg::buf_write_type              buf_wr
);

   import rft_pkg::*;

   localparam int LenW = $clog2(MAX_LEN + 1);

   logic [LenW-1:0]       len_ff, len_in;
   logic                  ovf_ff, ovf_in;
   logic [RAIL_CFG_W-1:0] rail_count_ff, rail_count_in;
   logic                  decode_ff, decode_in;

   logic                  accept;
   logic                  has_room;
   logic [LenW-1:0]       len_next;
   logic                  ovf_next;
   logic [CNT_W-1:0]      rails_eff;

   assign req_tready = queue_empty & ~back_busy;
   assign accept     = req_tvalid & req_tready;
   assign has_room   = len_ff < LenW'(MAX_LEN);
   assign len_next   = has_room ? len_ff + 1'b1 : len_ff;
   assign ovf_next   = ovf_ff | ~has_room;

   always_comb begin
      priority if (rail_count_ff == '0) begin
         rails_eff = CNT_W'(1);
      end else if (32'(rail_count_ff) > MAX_RAILS) begin
         rails_eff = CNT_W'(MAX_RAILS);
      end else begin
         rails_eff = CNT_W'(rail_count_ff);
      end
   end

   assign job_push       = accept & req_tlast;
   assign job.len        = CNT_W'(len_next);
   assign job.rails      = rails_eff;
   assign job.truncated  = ovf_next;
   assign job.decode     = decode_ff;
   assign job.passthru   = (rails_eff == CNT_W'(1)) || (rails_eff > CNT_W'(len_next));

   assign buf_wr.en   = accept & has_room;
   assign buf_wr.addr = CNT_W'(len_ff);
   assign buf_wr.data = req_tdata;

   always_comb begin
      rail_count_in = rail_count_ff;
      decode_in     = decode_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_RAIL_COUNT:  rail_count_in = csr_wdata[RAIL_CFG_W-1:0];
            CSR_DECODE_MODE: decode_in     = csr_wdata[0];
            default:         rail_count_in = rail_count_ff;
         endcase
      end

      len_in = len_ff;
      ovf_in = ovf_ff;
      if (accept) begin
         if (req_tlast) begin
            len_in = '0;
            ovf_in = 1'b0;
         end else begin
            len_in = len_next;
            ovf_in = ovf_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff        <= '0;
         ovf_ff        <= 1'b0;
         rail_count_ff <= RAIL_COUNT_RESET;
         decode_ff     <= 1'b0;
      end else begin
         len_ff        <= len_in;
         ovf_ff        <= ovf_in;
         rail_count_ff <= rail_count_in;
         decode_ff     <= decode_in;
      end
   end

   `RFT_ASSERT_IMPLY(a_len_bound, clock, reset, 1'b1, len_ff <= LenW'(MAX_LEN))
   `RFT_ASSERT_IMPLY(a_ovf_full, clock, reset, ovf_ff, len_ff == LenW'(MAX_LEN))
   `RFT_ASSERT_NEXT(a_clear_after_last, clock, reset, job_push, (len_ff == '0) && !ovf_ff)
   `RFT_ASSERT_IMPLY(a_job_nonempty, clock, reset, job_push, job.len != '0)

endmodule

`default_nettype wire

// ----- rtl/rft_queue.sv -----
`default_nettype none

module rft_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rft_pkg::job_type push_job,
   input  logic             pop,
   output rft_pkg::job_type pop_job,
   output logic             empty
);

   import rft_pkg::*;

   localparam int Depth = 2;
   localparam int PtrW  = $clog2(Depth);
   localparam int CntW  = $clog2(Depth + 1);

   job_type         slot_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push;
   logic            do_pop;

   assign empty   = count_ff == '0;
   assign do_push = push && (count_ff != CntW'(Depth));
   assign do_pop  = pop && !empty;
   assign pop_job = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/rft_back.sv -----
`default_nettype none

`include "rail_fence_transposer_unit_macros.svh"

module rft_back #(
   parameter int MAX_LEN   = rft_pkg::MAX_LEN_DEFAULT,
   parameter int MAX_RAILS = rft_pkg::MAX_RAILS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       queue_empty,
   input  rft_pkg::job_type           queue_job,
   output logic                       queue_pop,
   input  rft_pkg::buf_write_type     buf_wr,
   output logic                       busy,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [rft_pkg::BYTE_W-1:0] rsp_tdata,
   output logic                       rsp_tlast,
   output logic                       rsp_tuser
);

   import rft_pkg::*;

   localparam int LenW  = $clog2(MAX_LEN + 1);
   localparam int AddrW = $clog2(MAX_LEN);
   localparam int RailW = $clog2(MAX_RAILS);
   localparam int SumW  = LenW + 2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COUNT,
      ST_PREFIX,
      ST_EMIT
   } state_type;

   logic [BYTE_W-1:0] buffer_mem [MAX_LEN];

   state_type         state_ff, state_in;
   job_type           job_ff, job_in;
   logic [LenW-1:0]   step_ff, step_in;
   logic [RailW-1:0]  walk_rail_ff, walk_rail_in;
   logic              walk_down_ff, walk_down_in;
   logic [LenW-1:0]   cursor_ff [MAX_RAILS];
   logic [LenW-1:0]   cursor_in [MAX_RAILS];
   logic [LenW-1:0]   acc_ff, acc_in;
   logic [RailW-1:0]  pidx_ff, pidx_in;
   logic [RailW-1:0]  enc_rail_ff, enc_rail_in;
   logic [SumW-1:0]   enc_addr_ff, enc_addr_in;
   logic              enc_alt_ff, enc_alt_in;
   logic              rd_valid_ff, rd_valid_in;
   logic              rd_last_ff, rd_last_in;
   logic [BYTE_W-1:0] rd_data_ff;
   logic              out_valid_ff, out_valid_in;
   logic              out_last_ff, out_last_in;
   logic [BYTE_W-1:0] out_data_ff, out_data_in;

   logic [LenW-1:0]   len_w;
   logic [RailW-1:0]  rails_m1;
   logic [RailW-1:0]  walk_step;
   logic              walk_turn;
   logic              advance;
   logic              issue;
   logic              is_final;
   logic [AddrW-1:0]  rd_addr;
   logic [SumW-1:0]   period;
   logic [SumW-1:0]   rail_ext;
   logic              edge_rail;
   logic [SumW-1:0]   enc_step;
   logic [SumW-1:0]   enc_next;
   logic              enc_wrap;

   assign len_w     = job_ff.len[LenW-1:0];
   assign rails_m1  = RailW'(job_ff.rails - 1'b1);
   assign walk_step = walk_down_ff ? walk_rail_ff + 1'b1 : walk_rail_ff - 1'b1;
   assign walk_turn = (walk_step == '0) || (walk_step == rails_m1);
   assign is_final  = step_ff == len_w - 1'b1;

   assign advance = rd_valid_ff & (~out_valid_ff | rsp_tready);
   assign issue   = (state_ff == ST_EMIT) & (~rd_valid_ff | advance);

   // zigzag address walk over one rail for encoding
   assign period   = SumW'(rails_m1) << 1;
   assign rail_ext = SumW'(enc_rail_ff);
   assign edge_rail = (enc_rail_ff == '0) || (enc_rail_ff == rails_m1);
   assign enc_step = edge_rail ? period
                   : (enc_alt_ff ? rail_ext << 1 : period - (rail_ext << 1));
   assign enc_next = enc_addr_ff + enc_step;
   assign enc_wrap = enc_next >= SumW'(len_w);

   always_comb begin
      priority if (job_ff.passthru) begin
         rd_addr = step_ff[AddrW-1:0];
      end else if (job_ff.decode) begin
         rd_addr = cursor_ff[walk_rail_ff][AddrW-1:0];
      end else begin
         rd_addr = enc_addr_ff[AddrW-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      step_in      = step_ff;
      walk_rail_in = walk_rail_ff;
      walk_down_in = walk_down_ff;
      cursor_in    = cursor_ff;
      acc_in       = acc_ff;
      pidx_in      = pidx_ff;
      enc_rail_in  = enc_rail_ff;
      enc_addr_in  = enc_addr_ff;
      enc_alt_in   = enc_alt_ff;
      queue_pop    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               queue_pop    = 1'b1;
               job_in       = queue_job;
               step_in      = '0;
               walk_rail_in = '0;
               walk_down_in = 1'b1;
               acc_in       = '0;
               pidx_in      = '0;
               enc_rail_in  = '0;
               enc_addr_in  = '0;
               enc_alt_in   = 1'b0;
               for (int r = 0; r < MAX_RAILS; r++) begin
                  cursor_in[r] = '0;
               end
               if (queue_job.passthru || !queue_job.decode) begin
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_COUNT;
               end
            end
         end
         // rail lengths
         ST_COUNT: begin
            cursor_in[walk_rail_ff] = cursor_ff[walk_rail_ff] + 1'b1;
            walk_rail_in = walk_step;
            walk_down_in = walk_down_ff ^ walk_turn;
            step_in      = step_ff + 1'b1;
            if (is_final) begin
               step_in  = '0;
               state_in = ST_PREFIX;
            end
         end
         // rail lengths to rail start offsets
         ST_PREFIX: begin
            cursor_in[pidx_ff] = acc_ff;
            acc_in  = acc_ff + cursor_ff[pidx_ff];
            pidx_in = pidx_ff + 1'b1;
            if (pidx_ff == rails_m1) begin
               walk_rail_in = '0;
               walk_down_in = 1'b1;
               state_in     = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (issue) begin
               step_in = step_ff + 1'b1;
               if (!job_ff.passthru && job_ff.decode) begin
                  cursor_in[walk_rail_ff] = cursor_ff[walk_rail_ff] + 1'b1;
                  walk_rail_in = walk_step;
                  walk_down_in = walk_down_ff ^ walk_turn;
               end else if (!job_ff.passthru) begin
                  if (enc_wrap) begin
                     enc_rail_in = enc_rail_ff + 1'b1;
                     enc_addr_in = rail_ext + 1'b1;
                     enc_alt_in  = 1'b0;
                  end else begin
                     enc_addr_in = enc_next;
                     enc_alt_in  = ~enc_alt_ff;
                  end
               end
               if (is_final) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rd_valid_in  = rd_valid_ff;
      rd_last_in   = rd_last_ff;
      out_valid_in = out_valid_ff;
      out_last_in  = out_last_ff;
      out_data_in  = out_data_ff;
      if (issue) begin
         rd_valid_in = 1'b1;
         rd_last_in  = is_final;
      end else if (advance) begin
         rd_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in = 1'b1;
         out_last_in  = rd_last_ff;
         out_data_in  = rd_data_ff;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rd_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rd_valid_ff  <= rd_valid_in;
         out_valid_ff <= out_valid_in;
      end
      job_ff       <= job_in;
      walk_rail_ff <= walk_rail_in;
      walk_down_ff <= walk_down_in;
      cursor_ff    <= cursor_in;
      acc_ff       <= acc_in;
      pidx_ff      <= pidx_in;
      enc_rail_ff  <= enc_rail_in;
      enc_addr_ff  <= enc_addr_in;
      enc_alt_ff   <= enc_alt_in;
      rd_last_ff   <= rd_last_in;
      out_last_ff  <= out_last_in;
      out_data_ff  <= out_data_in;
   end

   always_ff @(posedge clock) begin
      if (buf_wr.en) begin
         buffer_mem[buf_wr.addr[AddrW-1:0]] <= buf_wr.data;
      end
      if (issue) begin
         rd_data_ff <= buffer_mem[rd_addr];
      end
   end

   assign busy       = (state_ff != ST_IDLE) || rd_valid_ff || out_valid_ff;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = job_ff.truncated;

   `RFT_ASSERT_IMPLY(a_step_bound, clock, reset, state_ff == ST_EMIT, step_ff < len_w)
   `RFT_ASSERT_NEXT(a_done_after_last, clock, reset, rsp_tvalid && rsp_tready && rsp_tlast, (state_ff == ST_IDLE) && !rd_valid_ff)
   `RFT_ASSERT_NEXT(a_prefix_total, clock, reset, (state_ff == ST_PREFIX) && (pidx_ff == rails_m1), acc_ff == len_w)
   `RFT_ASSERT_IMPLY(a_nothing_behind_last, clock, reset, out_valid_ff && out_last_ff, !rd_valid_ff)

endmodule

`default_nettype wire

// ----- rtl/rail_fence_transposer_unit.sv -----
`default_nettype none

// channel   dir   handshake              payload
// req_      in    req_tvalid/tready      tdata: data_byte, tlast: last_in
// rsp_      out   rsp_tvalid/tready      tdata: out_byte, tlast: last_out, tuser: truncated
// csr_      in    csr_we                 csr_index, csr_wdata
//
// message bytes load at one beat per cycle into the buffer memory while req_tready is high
// rsp_tvalid rises once the job has passed the queue, state, read and output registers,
// then one beat per cycle unless stalled; decode first counts rail lengths, then offsets
// req_tready stays low from the last beat until the whole burst has been taken
// rsp_tready low stalls the read pipeline; reset is synchronous, no clearing pass

module rail_fence_transposer_unit #(
   parameter int MAX_LEN   = rft_pkg::MAX_LEN_DEFAULT,
   parameter int MAX_RAILS = rft_pkg::MAX_RAILS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [rft_pkg::BYTE_W-1:0]      req_tdata,   // data_byte
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [rft_pkg::BYTE_W-1:0]      rsp_tdata,   // out_byte
   output logic                            rsp_tlast,
   output logic                            rsp_tuser,   // truncated
   input  logic                            csr_we,
   input  logic [rft_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rft_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   import rft_pkg::*;

   logic          queue_empty;
   logic          back_busy;
   logic          job_push;
   logic          queue_pop;
   job_type       push_job;
   job_type       pop_job;
   buf_write_type buf_wr;

   rft_front #(
      .MAX_LEN   (MAX_LEN),
      .MAX_RAILS (MAX_RAILS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .queue_empty (queue_empty),
      .back_busy   (back_busy),
      .job_push    (job_push),
      .job         (push_job),
      .buf_wr      (buf_wr)
   );

   rft_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (push_job),
      .pop      (queue_pop),
      .pop_job  (pop_job),
      .empty    (queue_empty)
   );

   rft_back #(
      .MAX_LEN   (MAX_LEN),
      .MAX_RAILS (MAX_RAILS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .queue_job   (pop_job),
      .queue_pop   (queue_pop),
      .buf_wr      (buf_wr),
      .busy        (back_busy),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
`default_nettype none

module tb;
   import rft_pkg::*;

   localparam int MSG_MAX        = rft_pkg::MAX_LEN_DEFAULT;
   localparam int RAILS_MAX      = rft_pkg::MAX_RAILS_DEFAULT;
   localparam int RANDOM_BEATS   = 200;
   localparam int QUIET_TAIL     = 30;
   localparam int HOLD_CYCLES    = 400;
   localparam int CSR_SETTLE     = 4;
   localparam int END_SETTLE     = 20;
   localparam int CYCLE_LIMIT    = 200000;
   localparam int DIRECTED_ROWS  = 22;
   localparam int PRINT_LIMIT    = 50;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       trunc;
   } cipher_beat_t;

   typedef struct packed {
      logic [4:0] rails;
      logic       decode;
      logic [7:0] data;
      logic       last;
      logic       fixed;
      logic [7:0] want;
   } directed_row_t;

   logic clock = 1'b0;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [BYTE_W-1:0] req_tdata;
   logic req_tlast;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [BYTE_W-1:0] rsp_tdata;
   logic rsp_tlast;
   logic rsp_tuser;
   logic csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // rail count, decode flag, byte, last, typed-in flag, typed-in output byte
   directed_row_t directed_table [DIRECTED_ROWS] = '{
      '{5'd2,  1'b0, 8'h00, 1'b0, 1'b0, 8'h00},
      '{5'd2,  1'b0, 8'h00, 1'b1, 1'b0, 8'h00},
      '{5'd2,  1'b0, 8'hff, 1'b1, 1'b1, 8'hff},
      '{5'd2,  1'b0, 8'h48, 1'b0, 1'b0, 8'h00},
      '{5'd2,  1'b0, 8'h45, 1'b0, 1'b0, 8'h00},
      '{5'd2,  1'b0, 8'h4c, 1'b0, 1'b0, 8'h00},
      '{5'd2,  1'b0, 8'h4c, 1'b0, 1'b0, 8'h00},
      '{5'd2,  1'b0, 8'h4f, 1'b1, 1'b0, 8'h00},
      '{5'd3,  1'b1, 8'h5a, 1'b0, 1'b0, 8'h00},
      '{5'd3,  1'b1, 8'ha5, 1'b0, 1'b0, 8'h00},
      '{5'd3,  1'b1, 8'h01, 1'b0, 1'b0, 8'h00},
      '{5'd3,  1'b1, 8'h80, 1'b0, 1'b0, 8'h00},
      '{5'd3,  1'b1, 8'h7f, 1'b0, 1'b0, 8'h00},
      '{5'd3,  1'b1, 8'hc3, 1'b1, 1'b0, 8'h00},
      '{5'd1,  1'b0, 8'h11, 1'b0, 1'b0, 8'h00},
      '{5'd1,  1'b0, 8'h22, 1'b0, 1'b0, 8'h00},
      '{5'd1,  1'b0, 8'h33, 1'b1, 1'b0, 8'h00},
      '{5'd0,  1'b0, 8'h96, 1'b0, 1'b0, 8'h00},
      '{5'd0,  1'b0, 8'h69, 1'b1, 1'b0, 8'h00},
      '{5'd31, 1'b1, 8'hde, 1'b0, 1'b0, 8'h00},
      '{5'd31, 1'b1, 8'had, 1'b1, 1'b0, 8'h00},
      '{5'd16, 1'b0, 8'h5c, 1'b1, 1'b1, 8'h5c}
   };

   logic [7:0] msg_buf [MSG_MAX];
   int msg_len;
   logic msg_trunc;
   logic [4:0] cfg_rails;
   logic cfg_decode;

   cipher_beat_t pending_cipher_beats [$];
   cipher_beat_t want_beat;
   int mismatches;
   int cycle_count;
   logic idle_on;
   logic hold_start;
   int hold_left;
   int stall_left;

   rail_fence_transposer_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      if (mismatches < PRINT_LIMIT) begin
         $display("mismatch at cycle %0d: %s", cycle_count, what);
      end
      mismatches++;
   endtask

   task automatic transpose_message();
      int n, rails, rail, i, r, k, acc, src;
      logic down;
      int pos_rail [MSG_MAX];
      int rail_len [RAILS_MAX];
      int cursor [RAILS_MAX];
      logic [7:0] shuffled [MSG_MAX];
      cipher_beat_t beat;
      n = msg_len;
      rails = int'(cfg_rails);
      if (rails == 0) rails = 1;
      if (rails > RAILS_MAX) rails = RAILS_MAX;
      if (rails == 1 || rails > n) begin
         for (i = 0; i < n; i++) shuffled[i] = msg_buf[i];
      end else begin
         for (r = 0; r < RAILS_MAX; r++) rail_len[r] = 0;
         rail = 0;
         down = 1'b1;
         for (i = 0; i < n; i++) begin
            pos_rail[i] = rail;
            rail_len[rail]++;
            rail = down ? rail + 1 : rail - 1;
            if (rail == 0 || rail == rails - 1) down = !down;
         end
         if (!cfg_decode) begin
            k = 0;
            for (r = 0; r < rails; r++) begin
               for (i = 0; i < n; i++) begin
                  if (pos_rail[i] == r) begin
                     shuffled[k] = msg_buf[i];
                     k++;
                  end
               end
            end
         end else begin
            acc = 0;
            for (r = 0; r < rails; r++) begin
               cursor[r] = acc;
               acc += rail_len[r];
            end
            for (i = 0; i < n; i++) begin
               src = cursor[pos_rail[i]];
               cursor[pos_rail[i]]++;
               shuffled[i] = msg_buf[src];
            end
         end
      end
      for (k = 0; k < n; k++) begin
         beat.data = shuffled[k];
         beat.last = (k == n - 1);
         beat.trunc = msg_trunc;
         pending_cipher_beats.push_back(beat);
      end
   endtask

   task automatic load_byte(input logic [7:0] d, input logic l, input logic fixed,
                            input logic [7:0] want);
      cipher_beat_t beat;
      if (msg_len < MSG_MAX) begin
         msg_buf[msg_len] = d;
         msg_len++;
      end else begin
         msg_trunc = 1'b1;
      end
      if (l) begin
         if (fixed) begin
            beat.data = want;
            beat.last = 1'b1;
            beat.trunc = 1'b0;
            pending_cipher_beats.push_back(beat);
         end else begin
            transpose_message();
         end
         msg_len = 0;
         msg_trunc = 1'b0;
      end
   endtask

   // called and returns at a falling edge
   task automatic send_beat(input logic [7:0] d, input logic l, input logic fixed,
                            input logic [7:0] want);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = d;
      req_tlast = l;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      load_byte(d, l, fixed, want);
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [4:0] val);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      if (idx == CSR_RAIL_COUNT) cfg_rails = val;
      else cfg_decode = val[0];
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic wait_until_drained(input int settle);
      while (pending_cipher_beats.size() != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   // receiver side
   initial begin
      rsp_tready = 1'b0;
      hold_left = 0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_start) begin
            hold_start = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_tready = 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_tready = 1'b0;
            stall_left--;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_tready = 1'b0;
            stall_left = $urandom_range(0, 18);
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_cipher_beats.size() == 0) begin
            report_mismatch($sformatf("unexpected beat %h", rsp_tdata));
         end else begin
            want_beat = pending_cipher_beats.pop_front();
            if (rsp_tdata !== want_beat.data)
               report_mismatch($sformatf("out_byte %h, want %h", rsp_tdata, want_beat.data));
            if (rsp_tlast !== want_beat.last)
               report_mismatch($sformatf("last_out %b, want %b", rsp_tlast, want_beat.last));
            if (rsp_tuser !== want_beat.trunc)
               report_mismatch($sformatf("truncated %b, want %b", rsp_tuser, want_beat.trunc));
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      int row, len, b, pick, msg_index, random_beats;
      logic quiet;
      logic [4:0] rails_val;
      cycle_count = 0;
      mismatches = 0;
      idle_on = 1'b1;
      hold_start = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      cfg_rails = RAIL_COUNT_RESET;
      cfg_decode = 1'b0;
      msg_len = 0;
      msg_trunc = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (row = 0; row < DIRECTED_ROWS; row++) begin
         if (row == 0 || directed_table[row-1].last) begin
            if (directed_table[row].rails != cfg_rails ||
                directed_table[row].decode != cfg_decode) begin
               wait_until_drained(CSR_SETTLE);
               if (directed_table[row].rails != cfg_rails)
                  write_csr(CSR_RAIL_COUNT, directed_table[row].rails);
               if (directed_table[row].decode != cfg_decode)
                  write_csr(CSR_DECODE_MODE, {4'b0, directed_table[row].decode});
            end
         end
         send_beat(directed_table[row].data, directed_table[row].last,
                   directed_table[row].fixed, directed_table[row].want);
      end

      msg_index = 0;
      random_beats = 0;
      while (random_beats < RANDOM_BEATS) begin
         if (random_beats >= RANDOM_BEATS - QUIET_TAIL) idle_on = 1'b0;
         pick = $urandom_range(0, 19);
         if (pick < 16) len = $urandom_range(1, 10);
         else if (pick < 18) len = $urandom_range(11, 40);
         else if (pick == 18) len = $urandom_range(41, MSG_MAX);
         else len = $urandom_range(MSG_MAX, MSG_MAX + 6);
         if (msg_index == 0) len = $urandom_range(MSG_MAX + 1, MSG_MAX + 8);
         if (msg_index == 1) len = MSG_MAX;
         quiet = (msg_index >= 4 && msg_index <= 7);
         if (msg_index < 2 || (!quiet && $urandom_range(0, 2) == 0)) begin
            pick = $urandom_range(0, 9);
            case (pick)
               0: rails_val = 5'd0;
               1: rails_val = 5'($urandom_range(17, 31));
               2: rails_val = 5'd16;
               3: rails_val = 5'd1;
               default: rails_val = 5'($urandom_range(2, 15));
            endcase
            if (msg_index == 1) rails_val = 5'd16;
            wait_until_drained(CSR_SETTLE);
            write_csr(CSR_RAIL_COUNT, rails_val);
            write_csr(CSR_DECODE_MODE, 5'($urandom_range(0, 31)));
         end
         // long receiver hold while the next messages keep coming
         if (msg_index == 4) hold_start = 1'b1;
         for (b = 0; b < len; b++) begin
            send_beat(8'($urandom_range(0, 255)), b == len - 1, 1'b0, 8'h00);
            random_beats++;
         end
         msg_index++;
      end
      req_tvalid = 1'b0;
      req_tlast = 1'b0;

      wait_until_drained(END_SETTLE);
      if (pending_cipher_beats.size() != 0)
         report_mismatch($sformatf("%0d beats never arrived", pending_cipher_beats.size()));
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+rtl
rtl/rft_pkg.sv
rtl/rft_front.sv
rtl/rft_queue.sv
rtl/rft_back.sv
rtl/rail_fence_transposer_unit.sv
tb/sv/tb.sv
